// File: rtl/gbn_pkg.sv
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared widths, reset values and codes of the go-back-N sender window.
// ----------------------------------------------------------------------------
package gbn_pkg;

  // Default ring depth
  localparam int WINDOW_SLOTS_DEF = 8;

  // Field widths
  localparam int CMD_W      = 2;
  localparam int SEQ_W      = 8;
  localparam int KIND_W     = 2;
  localparam int TIMEOUT_W  = 24;
  localparam int TICK_W     = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // Register reset values
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET   = 24'd200000;
  localparam logic [SEQ_W-1:0]     FIRST_SEQ_RESET = 8'd20;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_SEND = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ACK  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_NAK  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_TICK = 2'd3;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_NEW    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RETX   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REFUSE = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SEQ = 2'd1;

endpackage

// File: rtl/gbn_ram.sv
// ----------------------------------------------------------------------------
// gbn_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gbn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/go_back_n_sender_window_core.sv
// ----------------------------------------------------------------------------
// go_back_n_sender_window_core
// Retransmit bookkeeping for a go-back-N frame sender: slot ring, sequence
// numbers, deadlines, ACK / NAK / tick handling.
// ----------------------------------------------------------------------------
//  channel  | handshake               | payload
//  ---------+-------------------------+---------------------------------------
//  command  | start / busy            | in_cmd, in_seq_value
//  result   | out_valid (strobe)      | out_kind, out_slot, out_seq, out_last
//  config   | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
//  Send: its result appears in the cycle after busy falls. NAK and tick:
//  the last result appears in the cycle after busy falls. ACK: the scan
//  stops at the first matching frame or else runs to the newest frame,
//  no result. At most WINDOW_SLOTS-1 frames are scanned; each slot is
//  read in ST_RD and then evaluated in ST_EV.
//  Synchronous active-low reset; memories hold no reset state.
//  Results cannot be stalled: each appears for one cycle with out_valid.
// ----------------------------------------------------------------------------
module go_back_n_sender_window_core #(
  parameter int WINDOW_SLOTS = gbn_pkg::WINDOW_SLOTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // command transaction
  input  logic                              start,
  output logic                              busy,
  input  logic [gbn_pkg::CMD_W-1:0]         in_cmd,
  input  logic [gbn_pkg::SEQ_W-1:0]         in_seq_value,
  // result transaction
  output logic                              out_valid,
  output logic [gbn_pkg::KIND_W-1:0]        out_kind,
  output logic [$clog2(WINDOW_SLOTS)-1:0]   out_slot,
  output logic [gbn_pkg::SEQ_W-1:0]         out_seq,
  output logic                              out_last,
  // configuration transaction
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [gbn_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gbn_pkg::CFG_DATA_W-1:0]    cfg_data
);

  import gbn_pkg::*;

  localparam int SLOT_W = $clog2(WINDOW_SLOTS);

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SEND  = 3'd1;
  localparam logic [2:0] ST_RENEW = 3'd2;
  localparam logic [2:0] ST_RD    = 3'd3;
  localparam logic [2:0] ST_EV    = 3'd4;

  function automatic logic [SLOT_W-1:0] ring_next(input logic [SLOT_W-1:0] s);
    if (s == SLOT_W'(WINDOW_SLOTS - 1)) begin
      return '0;
    end else begin
      return s + 1'b1;
    end
  endfunction

  // control state
  logic [2:0]          state_r, state_nxt;
  logic [SLOT_W-1:0]   oldest_r, oldest_nxt;
  logic [SLOT_W-1:0]   next_slot_r, next_slot_nxt;
  logic [SLOT_W-1:0]   ptr_r, ptr_nxt;
  logic [SEQ_W-1:0]    next_seq_r, next_seq_nxt;
  logic [TICK_W-1:0]   tick_r, tick_nxt;
  logic [TIMEOUT_W-1:0] timeout_r, timeout_nxt;
  logic                on_r, on_nxt;
  logic                pend_vld_r, pend_vld_nxt;
  logic                out_valid_r, out_valid_nxt;

  // payload registers
  logic [CMD_W-1:0]    cmd_r, cmd_nxt;
  logic [SEQ_W-1:0]    val_r, val_nxt;
  logic [TICK_W-1:0]   renew_r, renew_nxt;
  logic [SLOT_W-1:0]   pend_slot_r, pend_slot_nxt;
  logic [SEQ_W-1:0]    pend_seq_r, pend_seq_nxt;
  logic [KIND_W-1:0]   out_kind_r, out_kind_nxt;
  logic [SLOT_W-1:0]   out_slot_r, out_slot_nxt;
  logic [SEQ_W-1:0]    out_seq_r, out_seq_nxt;
  logic                out_last_r, out_last_nxt;

  // memory ports
  logic                seq_we, dl_we;
  logic [SLOT_W-1:0]   seq_waddr, dl_waddr;
  logic [SEQ_W-1:0]    seq_wdata, seq_rdata;
  logic [TICK_W-1:0]   dl_wdata, dl_rdata;

  // shared adder / subtractor
  logic [TICK_W-1:0]   alu_a, alu_b, alu_y;
  logic                alu_sub;

  assign alu_y = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);

  gbn_ram #(.WIDTH(SEQ_W), .DEPTH(WINDOW_SLOTS)) u_seq_ram (
    .clk   (clk),
    .we    (seq_we),
    .waddr (seq_waddr),
    .wdata (seq_wdata),
    .raddr (ptr_r),
    .rdata (seq_rdata)
  );

  gbn_ram #(.WIDTH(TICK_W), .DEPTH(WINDOW_SLOTS)) u_dl_ram (
    .clk   (clk),
    .we    (dl_we),
    .waddr (dl_waddr),
    .wdata (dl_wdata),
    .raddr (ptr_r),
    .rdata (dl_rdata)
  );

  // sequencer and datapath
  always_comb begin
    logic hit;
    logic expired;
    logic emit;

    state_nxt     = state_r;
    oldest_nxt    = oldest_r;
    next_slot_nxt = next_slot_r;
    ptr_nxt       = ptr_r;
    next_seq_nxt  = next_seq_r;
    tick_nxt      = tick_r;
    timeout_nxt   = timeout_r;
    on_nxt        = on_r;
    pend_vld_nxt  = pend_vld_r;
    cmd_nxt       = cmd_r;
    val_nxt       = val_r;
    renew_nxt     = renew_r;
    pend_slot_nxt = pend_slot_r;
    pend_seq_nxt  = pend_seq_r;
    out_valid_nxt = 1'b0;
    out_kind_nxt  = out_kind_r;
    out_slot_nxt  = out_slot_r;
    out_seq_nxt   = out_seq_r;
    out_last_nxt  = out_last_r;

    seq_we    = 1'b0;
    seq_waddr = next_slot_r;
    seq_wdata = next_seq_r;
    dl_we     = 1'b0;
    dl_waddr  = next_slot_r;
    dl_wdata  = alu_y;

    alu_a   = tick_r;
    alu_b   = {{(TICK_W-TIMEOUT_W){1'b0}}, timeout_r};
    alu_sub = 1'b0;

    hit     = 1'b0;
    expired = 1'b0;
    emit    = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        // configuration writes
        if (cfg_valid) begin
          if (cfg_index == CFG_TIMEOUT) begin
            timeout_nxt = cfg_data[TIMEOUT_W-1:0];
          end else if (cfg_index == CFG_FIRST_SEQ) begin
            next_seq_nxt = cfg_data[SEQ_W-1:0];
          end
        end
        // command accept
        if (start) begin
          cmd_nxt      = in_cmd;
          val_nxt      = in_seq_value;
          ptr_nxt      = oldest_r;
          on_nxt       = 1'b0;
          pend_vld_nxt = 1'b0;
          unique case (in_cmd)
            CMD_SEND: state_nxt = ST_SEND;
            CMD_TICK: begin
              tick_nxt  = tick_r + 1'b1;
              state_nxt = ST_RENEW;
            end
            default:  state_nxt = ST_RD;
          endcase
        end
      end

      ST_SEND: begin
        // new frame or refusal, always a single result
        out_valid_nxt = 1'b1;
        out_slot_nxt  = next_slot_r;
        out_seq_nxt   = next_seq_r;
        out_last_nxt  = 1'b1;
        if (ring_next(next_slot_r) == oldest_r) begin
          out_kind_nxt = KIND_REFUSE;
        end else begin
          out_kind_nxt  = KIND_NEW;
          seq_we        = 1'b1;
          dl_we         = 1'b1;
          next_slot_nxt = ring_next(next_slot_r);
          next_seq_nxt  = next_seq_r + 1'b1;
        end
        state_nxt = ST_IDLE;
      end

      ST_RENEW: begin
        // renewed deadline for this tick
        renew_nxt = alu_y;
        state_nxt = ST_RD;
      end

      ST_RD: begin
        // end of scan: flush the held result as the last one
        if (ptr_r == next_slot_r) begin
          if (pend_vld_r) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = KIND_RETX;
            out_slot_nxt  = pend_slot_r;
            out_seq_nxt   = pend_seq_r;
            out_last_nxt  = 1'b1;
          end
          pend_vld_nxt = 1'b0;
          state_nxt    = ST_IDLE;
        end else begin
          state_nxt = ST_EV;
        end
      end

      ST_EV: begin
        // expiry check: sign of deadline - tick
        alu_a   = dl_rdata;
        alu_b   = tick_r;
        alu_sub = 1'b1;
        expired = alu_y[TICK_W-1];
        hit     = (seq_rdata == val_r);
        ptr_nxt   = ring_next(ptr_r);
        state_nxt = ST_RD;
        unique case (cmd_r)
          CMD_ACK: begin
            if (hit) begin
              oldest_nxt = ptr_r;
              state_nxt  = ST_IDLE;
            end
          end
          CMD_NAK: begin
            if (hit || on_r) begin
              on_nxt = 1'b1;
              emit   = 1'b1;
            end
          end
          CMD_TICK: begin
            if (expired) begin
              dl_we    = 1'b1;
              dl_waddr = ptr_r;
              dl_wdata = renew_r;
              emit     = 1'b1;
            end
          end
          default: state_nxt = ST_IDLE;
        endcase
        // hold the new result; release the previous one as not last
        if (emit) begin
          if (pend_vld_r) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = KIND_RETX;
            out_slot_nxt  = pend_slot_r;
            out_seq_nxt   = pend_seq_r;
            out_last_nxt  = 1'b0;
          end
          pend_vld_nxt  = 1'b1;
          pend_slot_nxt = ptr_r;
          pend_seq_nxt  = seq_rdata;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      oldest_r    <= '0;
      next_slot_r <= '0;
      ptr_r       <= '0;
      next_seq_r  <= FIRST_SEQ_RESET;
      tick_r      <= '0;
      timeout_r   <= TIMEOUT_RESET;
      on_r        <= 1'b0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      oldest_r    <= oldest_nxt;
      next_slot_r <= next_slot_nxt;
      ptr_r       <= ptr_nxt;
      next_seq_r  <= next_seq_nxt;
      tick_r      <= tick_nxt;
      timeout_r   <= timeout_nxt;
      on_r        <= on_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    val_r       <= val_nxt;
    renew_r     <= renew_nxt;
    pend_slot_r <= pend_slot_nxt;
    pend_seq_r  <= pend_seq_nxt;
    out_kind_r  <= out_kind_nxt;
    out_slot_r  <= out_slot_nxt;
    out_seq_r   <= out_seq_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_slot  = out_slot_r;
  assign out_seq   = out_seq_r;
  assign out_last  = out_last_r;

endmodule

// File: rtl/gbn_checker.sv
// ----------------------------------------------------------------------------
// gbn_checker
// Port-level checks on the sender window core, attached by bind.
// ----------------------------------------------------------------------------
module gbn_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_valid,
  input logic [gbn_pkg::KIND_W-1:0]    out_kind,
  input logic                          out_last
);

  import gbn_pkg::*;

  // an accepted command always occupies the block
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("command accepted but block not busy");

  // more results follow a non-final one, so the block is still working
  a_more_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy)
    else $error("non-final result while idle");

  // a new-frame transmit is the only result of its command
  a_new_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_NEW) |-> out_last)
    else $error("new frame result not marked last");

  // nothing follows the final result directly
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !out_valid)
    else $error("result directly after final result");

endmodule

bind go_back_n_sender_window_core gbn_checker u_gbn_checker (.*);
